// ----- src/rect_gap_distance_classify_unit_defines.svh -----
// ----------------------------------------------------------------------------
// rect_gap_distance_classify_unit_defines
// assertion macros shared by the rectangle gap distance unit
// ----------------------------------------------------------------------------
`ifndef RECT_GAP_DISTANCE_CLASSIFY_UNIT_DEFINES_SVH
`define RECT_GAP_DISTANCE_CLASSIFY_UNIT_DEFINES_SVH

// condition in one cycle implies the property in the same cycle
`define RGDC_ASSERT_NOW(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// condition in one cycle implies the property in the next cycle
`define RGDC_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/rgdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_pkg
// types, widths and helpers of the rectangle gap distance unit
// ----------------------------------------------------------------------------
package rgdc_pkg;

  localparam int COORD_BITS = 14;
  localparam int FRAC_BITS  = 8;
  localparam int DIST_W     = 24;
  localparam int POS_W      = 3;

  // edge coordinate: origin plus size
  localparam int EDGE_W  = COORD_BITS + 1;
  // square of one edge gap, and sum of two squares
  localparam int SQR_W   = 2 * EDGE_W;
  localparam int SUM_W   = SQR_W + 1;
  // radicand with the fraction bits of the root shifted in
  localparam int RAW_W   = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W  = (RAW_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  // single-axis distance
  localparam int LIN_W   = EDGE_W + FRAC_BITS;
  // common width for saturation
  localparam int EXT_W   = LIN_W + ROOT_W + DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [POS_W-1:0] {
    POS_UNKNOWN = 3'd0,
    POS_LEFT    = 3'd1,
    POS_RIGHT   = 3'd2,
    POS_UP      = 3'd3,
    POS_BOTTOM  = 3'd4
  } pos_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] a_left;
    logic [COORD_BITS-1:0] a_top;
    logic [COORD_BITS-1:0] a_width;
    logic [COORD_BITS-1:0] a_height;
    logic [COORD_BITS-1:0] b_left;
    logic [COORD_BITS-1:0] b_top;
    logic [COORD_BITS-1:0] b_width;
    logic [COORD_BITS-1:0] b_height;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] gap_distance;
    logic [POS_W-1:0]  relative_position;
  } out_word_t;

  // per-item result info that rides along the root pipeline
  typedef struct packed {
    pos_e             pos;
    logic             use_root;
    logic [LIN_W-1:0] lin;
  } side_t;

  // clamp to the distance range
  function automatic logic [DIST_W-1:0] sat_dist(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] lim;
    lim = EXT_W'(DIST_MAX);
    if (v > lim) begin
      return DIST_MAX;
    end
    return v[DIST_W-1:0];
  endfunction

endpackage

// ----- src/rgdc_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_geom
// two stages: rectangle edges, then separation test, gaps and position
// ----------------------------------------------------------------------------
module rgdc_geom
  import rgdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  in_word_t          word_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [EDGE_W-1:0] dx_o,
  output logic [EDGE_W-1:0] dy_o
);

  // stage a: edge coordinates
  logic              a_valid_q;
  logic [EDGE_W-1:0] ax0_q, ax1_q, ay0_q, ay1_q;
  logic [EDGE_W-1:0] bx0_q, bx1_q, by0_q, by1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax0_q <= EDGE_W'(word_i.a_left);
      ax1_q <= EDGE_W'(word_i.a_left) + EDGE_W'(word_i.a_width);
      ay0_q <= EDGE_W'(word_i.a_top);
      ay1_q <= EDGE_W'(word_i.a_top) + EDGE_W'(word_i.a_height);
      bx0_q <= EDGE_W'(word_i.b_left);
      bx1_q <= EDGE_W'(word_i.b_left) + EDGE_W'(word_i.b_width);
      by0_q <= EDGE_W'(word_i.b_top);
      by1_q <= EDGE_W'(word_i.b_top) + EDGE_W'(word_i.b_height);
    end
  end

  // stage b: separation, nearest edge gap and position
  logic              b_after_x, a_after_x, b_after_y, a_after_y;
  logic              apart_x, apart_y;
  logic [EDGE_W-1:0] dx_d, dy_d;
  side_t             side_d;

  always_comb begin
    b_after_x = bx0_q > ax1_q;
    a_after_x = ax0_q > bx1_q;
    b_after_y = by0_q > ay1_q;
    a_after_y = ay0_q > by1_q;
    apart_x   = b_after_x || a_after_x;
    apart_y   = b_after_y || a_after_y;
    // disjoint intervals: the nearest pair is the inner edges
    dx_d = b_after_x ? (bx0_q - ax1_q) : (ax0_q - bx1_q);
    dy_d = b_after_y ? (by0_q - ay1_q) : (ay0_q - by1_q);

    side_d.pos      = POS_UNKNOWN;
    side_d.use_root = 1'b0;
    side_d.lin      = '0;
    priority if (apart_x && apart_y) begin
      side_d.use_root = 1'b1;
    end else if (apart_x) begin
      side_d.lin = LIN_W'(dx_d) << FRAC_BITS;
      side_d.pos = (ax0_q < bx0_q) ? POS_LEFT : POS_RIGHT;
    end else if (apart_y) begin
      side_d.lin = LIN_W'(dy_d) << FRAC_BITS;
      side_d.pos = (ay0_q < by0_q) ? POS_UP : POS_BOTTOM;
    end else begin
      // overlap on both axes: zero distance, position unknown
      side_d.pos = POS_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_d;
      dx_o   <= dx_d;
      dy_o   <= dy_d;
    end
  end

endmodule

// ----- src/rgdc_sq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_sq
// two stages: square both gaps, then sum and scale into the radicand
// ----------------------------------------------------------------------------
module rgdc_sq
  import rgdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  side_t             side_i,
  input  logic [EDGE_W-1:0] dx_i,
  input  logic [EDGE_W-1:0] dy_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [RAD_W-1:0]  rad_o
);

  // stage c: squares
  logic             c_valid_q;
  side_t            c_side_q;
  logic [SQR_W-1:0] dx2_q, dy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= valid_i;
      valid_o   <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_side_q <= side_i;
      dx2_q    <= SQR_W'(dx_i) * SQR_W'(dx_i);
      dy2_q    <= SQR_W'(dy_i) * SQR_W'(dy_i);
    end
  end

  // stage d: sum of squares with the fraction bits appended
  logic [SUM_W-1:0] sum;

  assign sum = SUM_W'(dx2_q) + SUM_W'(dy2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= c_side_q;
      rad_o  <= RAD_W'(sum) << (2 * FRAC_BITS);
    end
  end

endmodule

// ----- src/rgdc_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_sqrt
// truncated square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module rgdc_sqrt
  import rgdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  side_t             side_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [ROOT_W-1:0] root_o
);

  // stage registers
  logic              stg_valid_q [ROOT_W];
  side_t             stg_side_q  [ROOT_W];
  logic [REM_W-1:0]  stg_rem_q   [ROOT_W];
  logic [ROOT_W-1:0] stg_root_q  [ROOT_W];
  logic [RAD_W-1:0]  stg_rad_q   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              cur_valid;
    side_t             cur_side;
    logic [REM_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [RAD_W-1:0]  cur_rad;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // stage input: pipeline input for the first stage
    if (k == 0) begin : g_first
      assign cur_valid = valid_i;
      assign cur_side  = side_i;
      assign cur_rem   = '0;
      assign cur_root  = '0;
      assign cur_rad   = rad_i;
    end else begin : g_next
      assign cur_valid = stg_valid_q[k-1];
      assign cur_side  = stg_side_q[k-1];
      assign cur_rem   = stg_rem_q[k-1];
      assign cur_root  = stg_root_q[k-1];
      assign cur_rad   = stg_rad_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1:RAD_W-2]};
      trial  = {cur_root, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_valid_q[k] <= 1'b0;
      end else if (en_i) begin
        stg_valid_q[k] <= cur_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_side_q[k] <= cur_side;
        stg_rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        stg_root_q[k] <= {cur_root[ROOT_W-2:0], ge};
        stg_rad_q[k]  <= cur_rad << 2;
      end
    end
  end

  assign valid_o = stg_valid_q[ROOT_W-1];
  assign side_o  = stg_side_q[ROOT_W-1];
  assign root_o  = stg_root_q[ROOT_W-1];

endmodule

// ----- src/rect_gap_distance_classify_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_gap_distance_classify_unit
// gap distance and relative position of two axis-aligned rectangles
// ----------------------------------------------------------------------------
// The input channel takes one word per rectangle pair (origin and size of
// each rectangle) with in_valid_i / in_stall_o; the output channel returns
// one word per pair, gap distance (8 fraction bits) and relative position,
// with out_valid_o / out_stall_i. A word moves when valid is high and stall
// is low.
// From input to output a word passes two geometry stages, two square/sum
// stages, one stage per root bit of the square root (24 stages) and the
// output register. Throughput is one word per cycle while no output word
// is held; the root pipeline, one bit per stage, sets the depth.
// Reset clears all valid bits; no word is in flight after reset.
// When the output word is held by out_stall_i the whole pipeline freezes
// and in_stall_o rises; empty slots freeze too, so bubbles are not squeezed
// out. While the output register is empty the pipeline keeps moving.
// ----------------------------------------------------------------------------
`include "rect_gap_distance_classify_unit_defines.svh"

module rect_gap_distance_classify_unit
  import rgdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // global advance: hold only while a finished word waits
  logic en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // geometry
  logic              geom_valid;
  side_t             geom_side;
  logic [EDGE_W-1:0] geom_dx, geom_dy;

  rgdc_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (geom_valid),
    .side_o  (geom_side),
    .dx_o    (geom_dx),
    .dy_o    (geom_dy)
  );

  // squares and radicand
  logic             sq_valid;
  side_t            sq_side;
  logic [RAD_W-1:0] sq_rad;

  rgdc_sq u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geom_valid),
    .side_i  (geom_side),
    .dx_i    (geom_dx),
    .dy_i    (geom_dy),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .rad_o   (sq_rad)
  );

  // square root
  logic              rt_valid;
  side_t             rt_side;
  logic [ROOT_W-1:0] rt_root;

  rgdc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .side_i  (sq_side),
    .rad_i   (sq_rad),
    .valid_o (rt_valid),
    .side_o  (rt_side),
    .root_o  (rt_root)
  );

  // output register: pick root or single-axis distance, saturate
  logic [DIST_W-1:0] dist_d;

  assign dist_d = rt_side.use_root ? sat_dist(EXT_W'(rt_root)) : sat_dist(EXT_W'(rt_side.lin));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_o.gap_distance      <= dist_d;
      out_word_o.relative_position <= rt_side.pos;
    end
  end

  // a held output word freezes the last root stage
  `RGDC_ASSERT_NEXT(a_freeze_root, out_valid_o && out_stall_i,
    $stable(rt_valid) && $stable(rt_root) && $stable(rt_side), "root stage moved under stall")

  // the corner case carries no side position
  `RGDC_ASSERT_NOW(a_root_pos, rt_valid && rt_side.use_root,
    rt_side.pos == POS_UNKNOWN, "root distance with a side position")

  // single-axis words that reach the output carry a whole-pixel gap with a side
  `RGDC_ASSERT_NEXT(a_lin_side, en && rt_valid && !rt_side.use_root && rt_side.lin != '0,
    out_word_o.relative_position != POS_UNKNOWN, "single-axis gap without position")

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rectangle gap distance unit
// ----------------------------------------------------------------------------
// Rectangle pairs go in from a queue that an initial block fills. The queue
// starts with hand-picked corner cases: touching and just-apart edges, each
// relative position, extreme coordinates and sizes. After those come random
// pairs, half placed edge to edge or overlapping. The expected word for each
// accepted pair is worked out in the bench and compared, field by field, with
// the words that come out in order. Random idle bursts fall on both sides
// until near the end of the run. A watchdog catches a hung pipeline.
// ----------------------------------------------------------------------------

module tb;
  import rgdc_pkg::*;

  localparam int RANDOM_PAIRS = 1300;
  localparam int CALM_TAIL    = 200;
  localparam int HANG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOWN_ERRORS = 10;

  typedef enum int {
    PLACE_AFTER,
    PLACE_BEFORE,
    PLACE_OVERLAP
  } placement_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  pairs_to_send[$];
  out_word_t gap_words_due[$];
  int        error_count = 0;
  int        calm_cycles = 0;
  int        send_idle = 0;
  int        hold_left = 0;
  int        hang_count = 0;
  logic      quiet;

  rect_gap_distance_classify_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [EDGE_W-1:0] abs_gap(input logic [EDGE_W-1:0] p,
                                                 input logic [EDGE_W-1:0] q);
    return (p > q) ? p - q : q - p;
  endfunction

  // nearest edge pair on one axis, tried over every pairing of an edge of each rectangle
  function automatic logic [EDGE_W-1:0] nearest_edges(input logic [EDGE_W-1:0] p0,
                                                       input logic [EDGE_W-1:0] p1,
                                                       input logic [EDGE_W-1:0] q0,
                                                       input logic [EDGE_W-1:0] q1);
    logic [EDGE_W-1:0] m;
    logic [EDGE_W-1:0] t;
    m = abs_gap(p0, q0);
    t = abs_gap(p0, q1);
    if (t < m) m = t;
    t = abs_gap(p1, q0);
    if (t < m) m = t;
    t = abs_gap(p1, q1);
    if (t < m) m = t;
    return m;
  endfunction

  // truncated integer square root, two radicand bits per step
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] probe;
    rest  = v;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [DIST_W-1:0] clamp_dist(input logic [63:0] v);
    return (v > 64'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
  endfunction

  function automatic out_word_t calc_gap_word(input in_word_t w);
    logic [EDGE_W-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic [EDGE_W-1:0] dx, dy;
    logic [63:0]       sq;
    logic              apart_x, apart_y;
    out_word_t         r;
    ax0 = EDGE_W'(w.a_left);
    ay0 = EDGE_W'(w.a_top);
    ax1 = ax0 + EDGE_W'(w.a_width);
    ay1 = ay0 + EDGE_W'(w.a_height);
    bx0 = EDGE_W'(w.b_left);
    by0 = EDGE_W'(w.b_top);
    bx1 = bx0 + EDGE_W'(w.b_width);
    by1 = by0 + EDGE_W'(w.b_height);
    apart_x = (bx0 > ax1) || (ax0 > bx1);
    apart_y = (by0 > ay1) || (ay0 > by1);
    dx = nearest_edges(ax0, ax1, bx0, bx1);
    dy = nearest_edges(ay0, ay1, by0, by1);
    r.gap_distance      = '0;
    r.relative_position = POS_UNKNOWN;
    if (apart_x && apart_y) begin
      sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
      r.gap_distance = clamp_dist(floor_sqrt(sq << (2 * FRAC_BITS)));
    end else if (apart_x) begin
      r.gap_distance      = clamp_dist(64'(dx) << FRAC_BITS);
      r.relative_position = (ax0 < bx0) ? POS_LEFT : POS_RIGHT;
    end else if (apart_y) begin
      r.gap_distance      = clamp_dist(64'(dy) << FRAC_BITS);
      r.relative_position = (ay0 < by0) ? POS_UP : POS_BOTTOM;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_pair(input int al, input int at, input int aw, input int ah,
                          input int bl, input int bt, input int bw, input int bh);
    in_word_t p;
    p.a_left   = al[COORD_BITS-1:0];
    p.a_top    = at[COORD_BITS-1:0];
    p.a_width  = aw[COORD_BITS-1:0];
    p.a_height = ah[COORD_BITS-1:0];
    p.b_left   = bl[COORD_BITS-1:0];
    p.b_top    = bt[COORD_BITS-1:0];
    p.b_width  = bw[COORD_BITS-1:0];
    p.b_height = bh[COORD_BITS-1:0];
    pairs_to_send.insert(pairs_to_send.size(), p);
  endtask

  // second rectangle on one axis: just past either edge, or overlapping
  task automatic place_axis(input int a0, input int asz, output int b0, output int bsz);
    placement_e where;
    bsz   = $urandom_range(0, 300);
    where = placement_e'($urandom_range(0, 2));
    case (where)
      PLACE_AFTER:  b0 = a0 + asz + $urandom_range(0, 3);
      PLACE_BEFORE: b0 = a0 - bsz - $urandom_range(0, 3);
      default:      b0 = a0 + $urandom_range(0, asz);
    endcase
  endtask

  task automatic add_random_pair();
    int al, at, aw, ah, bl, bt, bw, bh;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      // any bit pattern at all
      add_pair($urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 8) begin
      al = $urandom_range(400, 15900);
      at = $urandom_range(400, 15900);
      aw = $urandom_range(0, 300);
      ah = $urandom_range(0, 300);
      place_axis(al, aw, bl, bw);
      place_axis(at, ah, bt, bh);
      add_pair(al, at, aw, ah, bl, bt, bw, bh);
    end else begin
      // crowded small area
      add_pair($urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 31), $urandom_range(0, 31));
    end
  endtask

  // ---------------------------------------------------------------- idling

  // occasional stretches where neither side idles
  always @(posedge clk_i) begin
    if (calm_cycles > 0) begin
      calm_cycles <= calm_cycles - 1;
    end else if ($urandom_range(0, 99) == 0) begin
      calm_cycles <= $urandom_range(30, 120);
    end
  end

  assign quiet = (calm_cycles > 0) || (pairs_to_send.size() < CALM_TAIL);

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        gap_words_due.insert(gap_words_due.size(), calc_gap_word(in_word));
      end
      if (!in_valid || !in_stall) begin
        if (send_idle == 0 && !quiet && $urandom_range(0, 7) == 0) begin
          send_idle = $urandom_range(1, 11);
        end
        if (send_idle > 0) begin
          send_idle = send_idle - 1;
          in_valid <= 1'b0;
        end else if (pairs_to_send.size() > 0) begin
          in_word  <= pairs_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic note_error(input string what, input longint exp_v, input longint got_v);
    error_count++;
    if (error_count <= SHOWN_ERRORS) begin
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t due;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (gap_words_due.size() == 0) begin
          note_error("unexpected word, gap_distance", -1, out_word.gap_distance);
        end else begin
          due = gap_words_due.pop_front();
          if (out_word.gap_distance !== due.gap_distance) begin
            note_error("gap_distance", due.gap_distance, out_word.gap_distance);
          end
          if (out_word.relative_position !== due.relative_position) begin
            note_error("relative_position", due.relative_position,
                       out_word.relative_position);
          end
        end
      end
      // output back-pressure in bursts
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_count = 0;
      end else begin
        hang_count = hang_count + 1;
      end
      if (hang_count >= HANG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // both rectangles empty at the origin, and everything at maximum
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383);
    // edges touching in x, then one apart: left
    add_pair(0, 0, 10, 10, 10, 0, 5, 5);
    add_pair(0, 0, 10, 10, 11, 0, 5, 5);
    // second rectangle to the left: right
    add_pair(100, 0, 10, 10, 0, 0, 50, 10);
    // edges touching in y, then one apart: up
    add_pair(0, 0, 10, 10, 0, 10, 5, 5);
    add_pair(0, 0, 10, 10, 0, 11, 5, 5);
    // second rectangle above: bottom
    add_pair(0, 200, 10, 10, 0, 0, 5, 5);
    // apart on both axes, whole and fractional results
    add_pair(0, 0, 3, 4, 6, 8, 2, 2);
    add_pair(0, 0, 0, 0, 1, 1, 0, 0);
    add_pair(10, 10, 0, 0, 9, 9, 0, 0);
    // corners as far apart as the fields allow
    add_pair(0, 0, 0, 0, 16383, 16383, 16383, 16383);
    add_pair(16383, 16383, 16383, 16383, 0, 0, 0, 0);
    // widest span touching in x, apart in y
    add_pair(0, 0, 16383, 0, 16383, 16383, 16383, 16383);
    // largest sizes meeting at one corner
    add_pair(0, 0, 16383, 16383, 16383, 16383, 16383, 16383);
    // two identical points, then points on one vertical line
    add_pair(5, 5, 0, 0, 5, 5, 0, 0);
    add_pair(7, 0, 0, 0, 7, 20, 0, 0);
    // one rectangle inside the other
    add_pair(0, 0, 100, 100, 10, 10, 5, 5);
    // longest single-axis gaps
    add_pair(16383, 0, 16383, 10, 0, 0, 0, 10);
    add_pair(0, 16383, 10, 16383, 0, 0, 10, 0);
    add_pair(0, 0, 0, 16383, 16383, 0, 16383, 0);
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      add_random_pair();
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // run until every pair is in and every word is out
    do begin
      @(posedge clk_i);
    end while (pairs_to_send.size() > 0 || in_valid || gap_words_due.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
